@@ rtl/wfec_pkg.sv @@
// Shared constants and types for the windowed fault event counter.
// No dependencies.
package wfec_pkg;

  localparam int SLOTS    = 4;
  localparam int CHANNELS = 2;

  localparam int STAMP_W = 32;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int OUT_CNT_W = 3;
  localparam int COUNT_MAX = 7;

  localparam logic [7:0] CODE_LOW_WARN   = 8'h28;
  localparam logic [7:0] CODE_HIGH_WARN  = 8'h29;
  localparam logic [7:0] CODE_LOW_PAUSE  = 8'h30;
  localparam logic [7:0] CODE_HIGH_PAUSE = 8'h31;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd60000;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef stamp_t [SLOTS-1:0] row_t;

endpackage

@@ rtl/windowed_fault_event_counter_top.sv @@
// Top level of the windowed fault event counter: input register, row update, result register.
// Depends on wfec_pkg.
// Throughput is one event per clock while the result register can drain; an accepted
// event passes the input register and then the result register. The combinational update
// of a channel's slot row sits between these two registers, so each event sees the row left
// by the one before it. The result register accepts a new result while the old one is
// taken, and the input register refills in the same cycle it drains. Stamp rows clear at
// reset; no clearing pass is needed. Write cfg_window_ticks only while no events are in flight.
module windowed_fault_event_counter_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [31:0]             cfg_window_ticks,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_channel,
  input  logic [31:0]             in_event_tick,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_pause_request,
  output logic [7:0]              out_error_code,
  output logic [2:0]              out_recent_count
);
  import wfec_pkg::*;

  stamp_t                window_r;
  row_t                  stamps_r   [CHANNELS];
  row_t                  stamps_nxt [CHANNELS];

  logic                  s1_valid_r;
  logic                  s1_channel_r;
  stamp_t                s1_tick_r;
  logic                  s1_advance;

  logic                  out_valid_r;
  logic                  out_pause_r;
  logic [7:0]            out_code_r;
  logic [OUT_CNT_W-1:0]  out_count_r;

  logic                  row_sel;
  row_t                  cur_row;
  row_t                  upd_row;
  logic [CNT_W-1:0]      count;
  logic                  full;
  logic                  placed;
  stamp_t                age;
  logic [7:0]            code_nxt;
  logic [OUT_CNT_W-1:0]  count_sat;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  // a single-channel build folds the high channel onto row 0
  assign row_sel = (CHANNELS > 1) ? s1_channel_r : 1'b0;
  assign cur_row = stamps_r[row_sel];

  always_comb begin
    placed  = 1'b0;
    upd_row = cur_row;
    age     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      age = s1_tick_r - cur_row[i];
      if (cur_row[i] == '0 || age > window_r) begin
        upd_row[i] = placed ? '0 : s1_tick_r;
        placed     = 1'b1;
      end
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      count = count + CNT_W'(upd_row[i] != '0);
    end
  end

  assign full = (count == CNT_W'(SLOTS));

  always_comb begin
    for (int r = 0; r < CHANNELS; r++) begin
      stamps_nxt[r] = stamps_r[r];
      if (s1_advance && (row_sel == 1'(r))) begin
        stamps_nxt[r] = full ? '0 : upd_row;
      end
    end
  end

  always_comb begin
    if (s1_channel_r) begin
      code_nxt = full ? CODE_HIGH_PAUSE : CODE_HIGH_WARN;
    end else begin
      code_nxt = full ? CODE_LOW_PAUSE : CODE_LOW_WARN;
    end
  end

  assign count_sat = (count > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX) : OUT_CNT_W'(count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < CHANNELS; r++) begin
        stamps_r[r] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_ticks;
      end
      for (int r = 0; r < CHANNELS; r++) begin
        stamps_r[r] <= stamps_nxt[r];
      end
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_channel_r <= in_channel;
      s1_tick_r    <= in_event_tick;
    end
    if (s1_advance) begin
      out_pause_r <= full;
      out_code_r  <= code_nxt;
      out_count_r <= count_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pause_request = out_pause_r;
  assign out_error_code    = out_code_r;
  assign out_recent_count  = out_count_r;

  // a full row reports the saturated slot count
  a_pause_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pause_r |->
      out_count_r == ((SLOTS > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX) : OUT_CNT_W'(SLOTS)))
    else $error("pause reported without a full row count");

  a_code_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_pause_r == (out_code_r == CODE_LOW_PAUSE || out_code_r == CODE_HIGH_PAUSE)))
    else $error("error code disagrees with pause flag");

  // the row that filled is empty on the next cycle
  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && full |=> stamps_r[$past(row_sel)] == '0)
    else $error("full row not cleared");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty input register");

endmodule
